### rtl/core/ahlp_pkg.sv
// shared types, constants and helpers of the exposure histogram line parser
`timescale 1ns / 1ps

package ahlp_pkg;

    localparam int SCALE_BITS_DEF = 16;

    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 8;
    localparam int BIN_W     = 7;
    localparam int POS_W     = 3;
    localparam int LEN_W     = 3;
    localparam int BPP_W     = 4;
    localparam int REGION_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int QUADS_W   = 20;
    localparam int CNT_C_W   = 22;
    localparam int COUNT_W   = 30;
    localparam int AVG_W     = 16;
    localparam int STATUS_W  = 3;
    localparam int MIN_B_W   = 11;
    localparam int EB_W      = 24;

    localparam logic [BYTE_W-1:0] MARKER_BYTE    = 8'h55;
    localparam logic [IDX_W-1:0]  LIN_BINS       = 8'd128;
    localparam logic [IDX_W-1:0]  LOG_BINS       = 8'd9;
    localparam logic [IDX_W-1:0]  CHECK_ENTRY    = LIN_BINS + LOG_BINS;
    localparam logic [IDX_W-1:0]  MIN_ENTRIES    = 8'd144;
    localparam logic [4:0]        LOG_SHIFT_BASE = 5'd17;
    localparam logic [1:0]        LOG_WEIGHT_MUL = 2'd3;
    localparam logic [LEN_W-1:0]  MIN_ENTRY_LEN  = 3'd4;

    localparam logic [POS_W-1:0] POS_MARKER = 3'd3;
    localparam logic [POS_W-1:0] POS_CHECK  = 3'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_PIXELS = 3'd1,
        ST_NO_MARKER = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_TOO_SHORT = 3'd4
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic             clear;
        logic             load_byte;
        logic             pos0;
        logic [IDX_W-1:0] idx;
        logic             mark_lin;
        logic             mark_log;
        logic             push_bin;
        logic             push_final;
        t_status          final_status;
        logic             use_avg;
        logic             start_div;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [LEN_W-1:0] entry_len;
        logic             region_short;
        logic             marker_ok;
        logic             chk_eq;
        logic             count_zero;
        logic             div_done;
        logic             room;
    } t_stat;

    typedef struct packed {
        logic                kind;
        logic [BIN_W-1:0]    bin_index;
        logic [QUADS_W-1:0]  bin_quads;
        logic [AVG_W-1:0]    average;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_result;

    function automatic logic [LEN_W-1:0] entry_len(input logic [BPP_W-1:0] bpp);
        logic [LEN_W-1:0] n;
        n = bpp[BPP_W-1:1];
        return (n < MIN_ENTRY_LEN) ? MIN_ENTRY_LEN : n;
    endfunction

endpackage

### rtl/core/ahlp_in_if.sv
// byte channel into the histogram line parser
`timescale 1ns / 1ps

interface ahlp_in_if;
    import ahlp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              first;

    modport source (output valid, data_byte, first, input ready);
    modport sink   (input valid, data_byte, first, output ready);
endinterface

### rtl/core/ahlp_out_if.sv
// result channel out of the histogram line parser
`timescale 1ns / 1ps

interface ahlp_out_if;
    import ahlp_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [BIN_W-1:0]    bin_index;
    logic [QUADS_W-1:0]  bin_quads;
    logic [AVG_W-1:0]    average;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, kind, bin_index, bin_quads, average, status, last,
                    input ready);
    modport sink   (input valid, kind, bin_index, bin_quads, average, status, last,
                    output ready);
endinterface

### rtl/core/ahlp_div.sv
// restoring divider, one quotient bit per cycle, saturated quotient
`timescale 1ns / 1ps

module ahlp_div #(
    parameter int WS_W = 45
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [WS_W-1:0]              i_dividend,
    input  logic [ahlp_pkg::COUNT_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [ahlp_pkg::AVG_W-1:0]   o_quot
);
    import ahlp_pkg::*;

    localparam int CNT_W = $clog2(WS_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_d;
    logic [WS_W-1:0]    r_q;

    logic [COUNT_W:0]   rem_sh;
    logic [COUNT_W:0]   diff;
    logic               ge;

    always_comb begin
        rem_sh = {r_rem, r_q[WS_W-1]};
        diff   = rem_sh - {1'b0, r_d};
        ge     = (rem_sh >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WS_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_d   <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
            r_q   <= {r_q[WS_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = (|r_q[WS_W-1:AVG_W]) ? {AVG_W{1'b1}} : r_q[AVG_W-1:0];

endmodule

### rtl/core/ahlp_datapath.sv
// configuration, entry assembly, accumulators and result buffer
`timescale 1ns / 1ps

module ahlp_datapath #(
    parameter int SCALE_BITS = ahlp_pkg::SCALE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ahlp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ahlp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [ahlp_pkg::BYTE_W-1:0]    i_data_byte,
    input  ahlp_pkg::t_cmd                 i_cmd,
    output ahlp_pkg::t_stat                o_stat,
    output logic                           o_res_valid,
    output ahlp_pkg::t_result              o_res,
    input  logic                           i_res_ready
);
    import ahlp_pkg::*;

    localparam int WT_W   = SCALE_BITS;
    localparam int PROD_W = CNT_C_W + WT_W;
    localparam int WS_W   = SCALE_BITS + 29;
    localparam logic [SCALE_BITS+1:0] LOG_BASE = {LOG_WEIGHT_MUL, {SCALE_BITS{1'b0}}};

    logic [BPP_W-1:0]    r_bpp;
    logic [REGION_W-1:0] r_region;
    logic [EB_W-1:0]     r_eb;
    logic [COUNT_W-1:0]  r_count;
    logic [WS_W-1:0]     r_wsum;
    logic [QUADS_W-1:0]  r_sq;
    logic [PROD_W-1:0]   r_prod;
    logic                r_pend;
    logic                r_v0;
    logic                r_v1;
    t_result             r_q0;
    t_result             r_q1;

    logic [LEN_W-1:0]      len;
    logic [MIN_B_W-1:0]    min_bytes;
    logic [CNT_C_W-1:0]    c;
    logic [QUADS_W-1:0]    quads;
    logic [QUADS_W-1:0]    chk;
    logic [IDX_W-1:0]      li_full;
    logic [4:0]            shamt;
    logic [SCALE_BITS+1:0] log_full;
    logic [WT_W-1:0]       w_lin;
    logic [WT_W-1:0]       w_log;
    logic [WT_W-1:0]       w;
    logic                  acc_en;
    logic                  div_done;
    logic [AVG_W-1:0]      div_quot;
    logic                  push;
    logic                  pop;
    t_result               res_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp    <= BPP_W'(10);
            r_region <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BPP:    r_bpp    <= i_cfg_data[BPP_W-1:0];
                CFG_REGION: r_region <= i_cfg_data[REGION_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        len       = entry_len(r_bpp);
        min_bytes = MIN_B_W'(MIN_ENTRIES) * MIN_B_W'(len);
        c         = r_eb[EB_W-1:2];
        quads     = r_eb[EB_W-1:4];
        // check entry is compared at its third byte, so the high nibble comes live
        chk       = {r_eb[15:0], i_data_byte[7:4]};
        // linear weight: idx * 2^(s-7) + 2^(s-8)
        w_lin     = {i_cmd.idx[BIN_W-1:0], 1'b1, {(SCALE_BITS-8){1'b0}}};
        li_full   = i_cmd.idx - LIN_BINS;
        shamt     = LOG_SHIFT_BASE - {1'b0, li_full[3:0]};
        log_full  = LOG_BASE >> shamt;
        w_log     = log_full[WT_W-1:0];
        w         = i_cmd.mark_lin ? w_lin : w_log;
        acc_en    = (i_cmd.mark_lin && (i_cmd.idx != '0)) || i_cmd.mark_log;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_eb <= i_cmd.pos0 ? {{(EB_W-BYTE_W){1'b0}}, i_data_byte}
                               : {r_eb[EB_W-BYTE_W-1:0], i_data_byte};
        end
        if (acc_en) begin
            r_prod <= PROD_W'(c) * PROD_W'(w);
        end
        if (i_cmd.clear) begin
            r_count <= '0;
            r_wsum  <= '0;
            r_sq    <= '0;
        end else begin
            // product of the previous marker is registered first and added in the cycle after
            if (r_pend) begin
                r_wsum <= r_wsum + {{(WS_W-PROD_W){1'b0}}, r_prod};
            end
            if (acc_en) begin
                r_count <= r_count + {{(COUNT_W-CNT_C_W){1'b0}}, c};
            end
            if (i_cmd.mark_lin && (i_cmd.idx == IDX_W'(1))) begin
                r_sq <= quads;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= acc_en && !i_cmd.clear;
        end
    end

    ahlp_div #(
        .WS_W (WS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (r_wsum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        res_push = '0;
        if (i_cmd.push_final) begin
            res_push.kind    = 1'b1;
            res_push.average = i_cmd.use_avg ? div_quot : '0;
            res_push.status  = i_cmd.final_status;
            res_push.last    = 1'b1;
        end else begin
            res_push.bin_index = i_cmd.idx[BIN_W-1:0];
            res_push.bin_quads = quads;
            res_push.status    = ST_OK;
        end
        push = i_cmd.push_bin || i_cmd.push_final;
        pop  = r_v0 && i_res_ready;
    end

    // two-entry result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (pop) begin
                r_v0 <= r_v1 || push;
                r_v1 <= r_v1 && push;
            end else if (push) begin
                r_v0 <= 1'b1;
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= r_v1 ? r_q1 : res_push;
            r_q1 <= res_push;
        end else if (push) begin
            if (r_v0) begin
                r_q1 <= res_push;
            end else begin
                r_q0 <= res_push;
            end
        end
    end

    always_comb begin
        o_stat.entry_len    = len;
        o_stat.region_short = r_region < REGION_W'(min_bytes);
        o_stat.marker_ok    = (i_data_byte == MARKER_BYTE);
        o_stat.chk_eq       = (chk == r_sq);
        o_stat.count_zero   = (r_count == '0);
        o_stat.div_done     = div_done;
        o_stat.room         = !r_v1;
    end

    assign o_res_valid = r_v0;
    assign o_res       = r_q0;

    a_buf_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("second buffer entry valid without a head entry");

    a_buf_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_v1) |-> pop)
        else $error("result pushed into a full buffer");

endmodule

### rtl/core/ahlp_ctrl.sv
// line sequencer: byte and entry counters, decisions and result commands
`timescale 1ns / 1ps

module ahlp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_first,
    output logic            o_ready,
    input  ahlp_pkg::t_stat i_stat,
    output ahlp_pkg::t_cmd  o_cmd
);
    import ahlp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DIV
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;

    logic             acc;
    logic             active;
    logic             finished;
    logic [POS_W-1:0] pos_e;
    logic [IDX_W-1:0] idx_e;
    logic [POS_W:0]   pos_inc;

    always_comb begin
        o_ready  = (r_state != S_DIV) && i_stat.room;
        acc      = i_valid && o_ready;
        active   = acc && (i_first || (r_state == S_RUN));
        pos_e    = i_first ? '0 : r_pos;
        idx_e    = i_first ? '0 : r_idx;
        pos_inc  = {1'b0, pos_e} + 1'b1;
        finished = 1'b0;

        o_cmd              = '0;
        o_cmd.final_status = ST_OK;
        o_cmd.idx          = idx_e;
        o_cmd.clear        = acc && i_first;

        n_state = r_state;
        n_pos   = r_pos;
        n_idx   = r_idx;

        unique case (r_state)
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.push_final = 1'b1;
                    o_cmd.use_avg    = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_IDLE, S_RUN: begin
                if (active && i_first && i_stat.region_short) begin
                    o_cmd.push_final   = 1'b1;
                    o_cmd.final_status = ST_TOO_SHORT;
                    n_state            = S_IDLE;
                end else if (active) begin
                    n_state         = S_RUN;
                    o_cmd.load_byte = (pos_e < POS_MARKER);
                    o_cmd.pos0      = (pos_e == '0);
                    if (idx_e == CHECK_ENTRY) begin
                        if (pos_e == POS_CHECK) begin
                            finished = 1'b1;
                            // mismatch takes precedence over an empty count
                            if (!i_stat.chk_eq) begin
                                o_cmd.push_final   = 1'b1;
                                o_cmd.final_status = ST_MISMATCH;
                                n_state            = S_IDLE;
                            end else if (i_stat.count_zero) begin
                                o_cmd.push_final   = 1'b1;
                                o_cmd.final_status = ST_NO_PIXELS;
                                n_state            = S_IDLE;
                            end else begin
                                o_cmd.start_div = 1'b1;
                                n_state         = S_DIV;
                            end
                        end
                    end else if (pos_e == POS_MARKER) begin
                        if (!i_stat.marker_ok) begin
                            finished           = 1'b1;
                            o_cmd.push_final   = 1'b1;
                            o_cmd.final_status = ST_NO_MARKER;
                            n_state            = S_IDLE;
                        end else if (idx_e < LIN_BINS) begin
                            o_cmd.mark_lin = 1'b1;
                            o_cmd.push_bin = 1'b1;
                        end else begin
                            o_cmd.mark_log = 1'b1;
                        end
                    end
                    if (!finished) begin
                        if (pos_inc >= {1'b0, i_stat.entry_len}) begin
                            n_pos = '0;
                            n_idx = (idx_e < CHECK_ENTRY) ? idx_e + 1'b1 : idx_e;
                        end else begin
                            n_pos = pos_inc[POS_W-1:0];
                            n_idx = idx_e;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_idx   <= n_idx;
        end
    end

    a_div_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !o_ready)
        else $error("byte accepted while dividing");

    a_single_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.push_bin && o_cmd.push_final))
        else $error("two results in one cycle");

    a_div_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_div |=> (r_state == S_DIV))
        else $error("divider started without entering the divide state");

endmodule

### rtl/core/ae_histogram_line_parser.sv
// top level of the exposure histogram line parser
//
// i_in carries one embedded-data byte per transfer; first marks the first
// byte of a line. o_out carries results: one per linear bin (kind 0, at the
// marker byte of the bin) and one final result per line (kind 1, last 1)
// with the average and a status. The config port writes bits_per_pixel
// (index 0) and region_bytes (index 1); the user must do so only while the
// block is idle, which the block itself does not enforce. Throughput: one
// byte per cycle while input is not held off. At the third byte of a
// matching check entry with a nonzero count the average is computed by a
// restoring divider, one quotient bit per cycle; input is held off until
// the final result is buffered. A bin result is registered into the
// result buffer with its marker byte transfer, an error result with the
// offending byte. A two-entry result buffer lets bytes keep flowing while
// a result waits; a stalled receiver holds input off once both entries
// are full. Reset returns the block to idle: bytes are dropped until one
// with first set, and the registers take their defaults (10 and 0).
`timescale 1ns / 1ps

module ae_histogram_line_parser #(
    parameter int SCALE_BITS = ahlp_pkg::SCALE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ahlp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ahlp_pkg::CFG_W-1:0]     i_cfg_data,
    ahlp_in_if.sink                        i_in,
    ahlp_out_if.source                     o_out
);
    import ahlp_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_result res;
    logic    res_valid;
    logic    in_ready;

    ahlp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_first (i_in.first),
        .o_ready (in_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ahlp_datapath #(
        .SCALE_BITS (SCALE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_data_byte (i_in.data_byte),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (o_out.ready)
    );

    assign i_in.ready      = in_ready;
    assign o_out.valid     = res_valid;
    assign o_out.kind      = res.kind;
    assign o_out.bin_index = res.bin_index;
    assign o_out.bin_quads = res.bin_quads;
    assign o_out.average   = res.average;
    assign o_out.status    = res.status;
    assign o_out.last      = res.last;

endmodule
